// ----- design/chol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_pkg
// Shared constants and command/status types of the Cholesky factorization
// block.
// ----------------------------------------------------------------------------
package chol_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_ORDER);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ORD_W       = $clog2(MAX_ORDER + 1);

    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_SQRT = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_UPD  = 3'd3;

    typedef struct packed {
        logic              wr_load;   // store incoming element
        logic [ADDR_W-1:0] load_addr;
        logic              rd_a;      // read operand a at addr
        logic              rd_b;
        logic              rd_c;
        logic [ADDR_W-1:0] addr;      // shared read address
        logic              start;     // start op on latched operands
        logic [2:0]        op;
        logic [ADDR_W-1:0] wr_addr;   // result target
    } t_cmd;

    typedef struct packed {
        logic        done;
        logic        root_zero;
        logic        bad_pivot;
        logic [31:0] rdata;
    } t_stat;

    function automatic logic [ADDR_W-1:0] tri_pos(input logic [IDX_W:0] r,
                                                  input logic [IDX_W:0] c);
        logic [ADDR_W+IDX_W+1:0] p;
        begin
            p = ((r * (r + 1'b1)) >> 1) + c;
            return p[ADDR_W-1:0];
        end
    endfunction

endpackage

// ----- design/chol_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_in_if / chol_out_if
// Valid/ready channels of the Cholesky block.
// ----------------------------------------------------------------------------
interface chol_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] element_value;
    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface chol_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] factor_value;
    logic [2:0]  row_index;
    logic [2:0]  column_index;
    logic        last_result;
    logic        pivot_error;
    modport source (output valid, output factor_value, output row_index,
                    output column_index, output last_result, output pivot_error,
                    input ready);
    modport sink   (input valid, input factor_value, input row_index,
                    input column_index, input last_result, input pivot_error,
                    output ready);
endinterface

// ----- design/chol_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_datapath
// Triangle memory, operand registers and a multi-cycle arithmetic unit:
// bit-serial square root, restoring divider, and a multiply with
// a saturating subtract.
// ----------------------------------------------------------------------------
module chol_datapath
    import chol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_load_data,
    output t_stat       o_stat
);

    logic [31:0] r_mem [STORE_DEPTH];
    logic [31:0] r_rdata;
    logic        r_rd_a, r_rd_b, r_rd_c;
    logic [31:0] r_a, r_b, r_c;

    // unit state
    logic [2:0]  r_op;
    logic [6:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [47:0] r_rad;     // sqrt radicand
    logic [49:0] r_rem;     // sqrt remainder
    logic [23:0] r_root;
    logic [63:0] r_num;     // divider numerator magnitude
    logic [63:0] r_quo;
    logic [32:0] r_drem;
    logic        r_neg;
    logic [63:0] r_prod;
    logic [31:0] r_res;
    logic        r_wr;
    logic [ADDR_W-1:0] r_waddr;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_mem[r_waddr] <= r_res;
        end else if (i_cmd.wr_load) begin
            r_mem[i_cmd.load_addr] <= i_load_data;
        end
        r_rdata <= r_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_a <= 1'b0;
            r_rd_b <= 1'b0;
            r_rd_c <= 1'b0;
        end else begin
            r_rd_a <= i_cmd.rd_a;
            r_rd_b <= i_cmd.rd_b;
            r_rd_c <= i_cmd.rd_c;
        end
        if (r_rd_a) r_a <= r_rdata;
        if (r_rd_b) r_b <= r_rdata;
        if (r_rd_c) r_c <= r_rdata;
    end

    logic [49:0] sq_trial;
    logic [49:0] sq_rem_sh;
    logic [32:0] dv_sh;
    logic [31:0] a_mag;
    logic [63:0] pv_trunc;
    logic signed [64:0] diff;
    logic signed [63:0] mul_w;

    always_comb begin
        sq_rem_sh = {r_rem[47:0], r_rad[47:46]};
        sq_trial  = {24'd0, r_root, 2'b01};
        dv_sh     = {r_drem[31:0], r_num[63]};
        a_mag     = r_a[31] ? (~r_a + 32'd1) : r_a;
        mul_w     = $signed(r_b) * $signed(r_c);
        // divide product by 2^16, truncating toward zero
        pv_trunc  = r_prod[63] ? (~(((~r_prod) + 64'd1) >> 16) + 64'd1) : (r_prod >> 16);
        diff      = $signed({r_a[31], r_a}) - $signed({pv_trunc[63], pv_trunc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_wr   <= 1'b0;
            r_op   <= OP_NONE;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_wr   <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_cmd.op;
                r_waddr <= i_cmd.wr_addr;
                r_step  <= '0;
                r_rad   <= {r_a[31:0], 16'd0};
                r_rem   <= '0;
                r_root  <= '0;
                r_num   <= {16'd0, a_mag, 16'd0};
                r_quo   <= '0;
                r_drem  <= '0;
                r_neg   <= r_a[31];
            end else if (r_busy) begin
                r_step <= r_step + 7'd1;
                case (r_op)
                    OP_SQRT: begin
                        r_rad <= {r_rad[45:0], 2'b00};
                        if (sq_rem_sh >= sq_trial) begin
                            r_rem  <= sq_rem_sh - sq_trial;
                            r_root <= {r_root[22:0], 1'b1};
                        end else begin
                            r_rem  <= sq_rem_sh;
                            r_root <= {r_root[22:0], 1'b0};
                        end
                        if (r_step == 7'd23) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_wr   <= 1'b1;
                            r_res  <= (sq_rem_sh >= sq_trial) ?
                                      {8'd0, r_root[22:0], 1'b1} :
                                      {8'd0, r_root[22:0], 1'b0};
                        end
                    end
                    OP_DIV: begin
                        if (r_step < 7'd64) begin
                            r_num <= {r_num[62:0], 1'b0};
                            if (dv_sh >= {1'b0, r_b}) begin
                                r_drem <= dv_sh - {1'b0, r_b};
                                r_quo  <= {r_quo[62:0], 1'b1};
                            end else begin
                                r_drem <= dv_sh;
                                r_quo  <= {r_quo[62:0], 1'b0};
                            end
                        end else begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_wr   <= 1'b1;
                            if (r_neg) begin
                                r_res <= (r_quo > 64'h8000_0000) ? 32'h8000_0000
                                         : (~r_quo[31:0] + 32'd1);
                            end else begin
                                r_res <= (r_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                         : r_quo[31:0];
                            end
                        end
                    end
                    OP_UPD: begin
                        if (r_step == 7'd0) begin
                            r_prod <= mul_w;
                        end else begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_wr   <= 1'b1;
                            if (diff > 65'sh0_7FFF_FFFF)       r_res <= 32'h7FFF_FFFF;
                            else if (diff < -65'sh0_8000_0000) r_res <= 32'h8000_0000;
                            else                               r_res <= diff[31:0];
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_wr   <= 1'b1;
                        r_res  <= '0;
                    end
                endcase
            end
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.root_zero = (r_b == 32'd0);
    assign o_stat.bad_pivot = r_a[31] | (r_a == 32'd0);
    assign o_stat.rdata     = r_rdata;

endmodule

// ----- design/chol_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chol_ctrl
// Sequencer: load, column loop (root, scale, trailing update) and emission.
// ----------------------------------------------------------------------------
module chol_ctrl
    import chol_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ORD_W-1:0] i_order,
    input  logic             i_restart,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_row,
    output logic [2:0]       o_col,
    output logic             o_last,
    output logic             o_err,
    output t_cmd             o_cmd,
    input  t_stat            i_stat
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PIVRD = 4'd1;
    localparam logic [3:0] S_PIVW  = 4'd2;
    localparam logic [3:0] S_PIVGO = 4'd3;
    localparam logic [3:0] S_PIVWT = 4'd4;
    localparam logic [3:0] S_RTRD  = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CW    = 4'd7;
    localparam logic [3:0] S_CWT   = 4'd8;
    localparam logic [3:0] S_URD   = 4'd9;
    localparam logic [3:0] S_UW    = 4'd10;
    localparam logic [3:0] S_UWT   = 4'd11;
    localparam logic [3:0] S_ORD   = 4'd12;
    localparam logic [3:0] S_OW    = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W:0]   r_k, n_k, r_i, n_i, r_j, n_j;
    logic [1:0]       r_sub, n_sub;
    logic             r_err, n_err;
    logic [CNT_W-1:0] total;
    logic [CNT_W:0]   tri_n;
    logic [IDX_W:0]   nn;

    assign nn    = i_order[IDX_W:0];
    assign tri_n = nn * (nn + 1'b1);
    assign total = tri_n[CNT_W:1];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_sub   = r_sub;
        n_err   = r_err;
        o_cmd   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready      = 1'b1;
                o_cmd.load_addr = r_cnt[ADDR_W-1:0];
                if (i_in_valid) begin
                    o_cmd.wr_load = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 >= total) begin
                        n_state = S_PIVRD;
                        n_k     = '0;
                    end
                end
            end
            S_PIVRD: begin
                o_cmd.addr = tri_pos(r_k, r_k);
                o_cmd.rd_a = 1'b1;
                n_state = S_PIVW;
            end
            S_PIVW: n_state = S_PIVGO;
            S_PIVGO: begin
                o_cmd.wr_addr = tri_pos(r_k, r_k);
                o_cmd.start   = 1'b1;
                if (i_stat.bad_pivot) begin
                    n_err    = 1'b1;
                    o_cmd.op = OP_NONE;
                end else begin
                    o_cmd.op = OP_SQRT;
                end
                n_state = S_PIVWT;
            end
            S_PIVWT: if (i_stat.done) n_state = S_RTRD;
            S_RTRD: begin
                // root into operand b, then scale column below
                o_cmd.addr = tri_pos(r_k, r_k);
                o_cmd.rd_b = 1'b1;
                n_i     = r_k + 1'b1;
                n_sub   = '0;
                n_state = S_CRD;
            end
            S_CRD: begin
                if (r_i >= nn) begin
                    n_j     = r_k + 1'b1;
                    n_i     = r_k + 1'b1;
                    n_sub   = '0;
                    n_state = S_URD;
                end else begin
                    o_cmd.addr = tri_pos(r_i, r_k);
                    o_cmd.rd_a = 1'b1;
                    n_state = S_CW;
                end
            end
            S_CW: begin
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd1) begin
                    o_cmd.start   = 1'b1;
                    o_cmd.op      = i_stat.root_zero ? OP_NONE : OP_DIV;
                    o_cmd.wr_addr = tri_pos(r_i, r_k);
                    n_state = S_CWT;
                end
            end
            S_CWT: if (i_stat.done) begin
                n_i     = r_i + 1'b1;
                n_sub   = '0;
                n_state = S_CRD;
            end
            S_URD: begin
                if (r_j >= nn) begin
                    if (r_k + 1'b1 >= nn) begin
                        n_cnt   = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_ORD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_PIVRD;
                    end
                end else if (r_i >= nn) begin
                    n_j = r_j + 1'b1;
                    n_i = r_j + 1'b1;
                end else begin
                    // three reads: a=(i,j), b=(i,k), c=(j,k)
                    n_sub = r_sub + 2'd1;
                    case (r_sub)
                        2'd0: begin
                            o_cmd.addr = tri_pos(r_i, r_j);
                            o_cmd.rd_a = 1'b1;
                        end
                        2'd1: begin
                            o_cmd.addr = tri_pos(r_i, r_k);
                            o_cmd.rd_b = 1'b1;
                        end
                        default: begin
                            o_cmd.addr = tri_pos(r_j, r_k);
                            o_cmd.rd_c = 1'b1;
                            n_sub   = '0;
                            n_state = S_UW;
                        end
                    endcase
                end
            end
            S_UW: begin
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd1) begin
                    o_cmd.start   = 1'b1;
                    o_cmd.op      = OP_UPD;
                    o_cmd.wr_addr = tri_pos(r_i, r_j);
                    n_sub   = '0;
                    n_state = S_UWT;
                end
            end
            S_UWT: if (i_stat.done) begin
                n_i     = r_i + 1'b1;
                n_state = S_URD;
            end
            S_ORD: begin
                o_cmd.addr = tri_pos(r_i, r_j);
                n_state = S_OW;
            end
            S_OW: begin
                o_cmd.addr = tri_pos(r_i, r_j);
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.addr  = tri_pos(r_i, r_j);
                if (i_out_ready) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 >= total) begin
                        n_cnt   = '0;
                        n_err   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        if (r_j == r_i) begin
                            n_i = r_i + 1'b1;
                            n_j = '0;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_sub   <= '0;
            r_err   <= 1'b0;
        end else if (i_restart) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_sub   <= n_sub;
            r_err   <= n_err;
        end
    end

    assign o_row  = r_i[2:0];
    assign o_col  = r_j[2:0];
    assign o_last = (r_cnt + 1'b1 == total);
    assign o_err  = r_err;

endmodule

// ----- design/cholesky_factorization.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factorization
// Top level: APB register, sequencer and datapath.
// ----------------------------------------------------------------------------
// Load n(n+1)/2 lower-triangle elements row-major, one per cycle; the block
// then factors in place and emits L row-major, each element read through
// S_ORD and S_OW and held in S_OUT until taken. Factoring time is set by
// the shared arithmetic unit and the single memory read port. Writing
// matrix_size restarts the load.
module cholesky_factorization
    import chol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    chol_in_if.sink     in_ch,
    chol_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]       r_size;
    logic [ORD_W-1:0] order;
    logic             wr_en;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_MATRIX_SIZE)
                    & (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'(MAX_ORDER);
        end else if (wr_en) begin
            r_size <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, r_size} : 32'd0;
    assign order  = (r_size == 4'd0) ? ORD_W'(1) :
                    (r_size > 4'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(r_size);

    chol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_order     (order),
        .i_restart   (wr_en),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_row       (out_ch.row_index),
        .o_col       (out_ch.column_index),
        .o_last      (out_ch.last_result),
        .o_err       (out_ch.pivot_error),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    chol_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_load_data (in_ch.element_value),
        .o_stat      (stat)
    );

    assign out_ch.factor_value = stat.rdata;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cholesky_factorization: loads lower triangles over
// the input channel, factors them in a local fixed-point model and compares
// every emitted factor element in order. Sizes and stall patterns vary.
// ----------------------------------------------------------------------------
module tb_top;
    import chol_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        err;
    } factor_t;

    localparam int LIMIT_CYCLES = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chol_in_if  in_ch ();
    chol_out_if out_ch ();

    cholesky_factorization dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic signed [31:0] tri_mem [STORE_DEPTH];
    int unsigned        loaded;
    bit                 err_flag;
    logic [3:0]         size_reg;

    factor_t     factor_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int order_of(input logic [3:0] s);
        if (s == 0) return 1;
        if (s > MAX_ORDER) return MAX_ORDER;
        return s;
    endfunction

    function automatic int tpos(input int r, input int c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7fffffff) return 32'sh7fffffff;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic factor_in_place(input int n);
        logic signed [31:0] piv;
        logic signed [31:0] root;
        logic signed [63:0] num;
        logic signed [63:0] prod;
        for (int k = 0; k < n; k++) begin
            piv = tri_mem[tpos(k, k)];
            root = 0;
            if (piv <= 0) err_flag = 1;
            else root = 32'(int_root({32'd0, piv} << 16));
            tri_mem[tpos(k, k)] = root;
            for (int i = k + 1; i < n; i++) begin
                if (root == 0) begin
                    tri_mem[tpos(i, k)] = 0;
                end else begin
                    num = 64'(tri_mem[tpos(i, k)]) * 65536;
                    tri_mem[tpos(i, k)] = clamp32(num / 64'(root));
                end
            end
            for (int j = k + 1; j < n; j++) begin
                for (int i = j; i < n; i++) begin
                    prod = 64'(tri_mem[tpos(i, k)]) * 64'(tri_mem[tpos(j, k)]);
                    tri_mem[tpos(i, j)] =
                        clamp32(64'(tri_mem[tpos(i, j)]) - prod / 65536);
                end
            end
        end
    endtask

    // load one element; on the last of the triangle queue the whole factor
    task automatic predict_factor(input logic [31:0] elem);
        int n;
        int total;
        int k;
        factor_t f;
        n = order_of(size_reg);
        total = n * (n + 1) / 2;
        if (loaded >= total) loaded = 0;
        tri_mem[loaded] = elem;
        loaded++;
        if (loaded < total) return;
        factor_in_place(n);
        k = 0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                f.value = tri_mem[tpos(r, c)];
                f.row = r[2:0];
                f.col = c[2:0];
                f.last = (k + 1 == total);
                f.err = err_flag;
                factor_q.push_back(f);
                k++;
            end
        end
        loaded = 0;
        err_flag = 0;
    endtask

    // valid stays high after a transfer until the next item or an idle cycle
    task automatic send_element(input logic [31:0] elem);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.element_value <= elem;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_factor(elem);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (factor_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MATRIX_SIZE, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        size_reg = v[3:0];
        loaded = 0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        factor_t got;
        factor_t want;
        if (i_rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.factor_value, out_ch.row_index, out_ch.column_index,
                   out_ch.last_result, out_ch.pivot_error};
            if (factor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %h", got);
            end else begin
                want = factor_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp v=%h r=%0d c=%0d l=%b e=%b, ",
                                  "got v=%h r=%0d c=%0d l=%b e=%b"},
                                 want.value, want.row, want.col, want.last, want.err,
                                 got.value, got.row, got.col, got.last, got.err);
                end
            end
        end
    end

    // symmetric positive definite: random off-diagonal terms under a dominant diagonal
    task automatic send_spd(input int n, input int scale);
        logic signed [31:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (r == c) v = (n * scale + $urandom_range(scale)) <<< 16;
                else v = $signed($urandom_range(2 * scale)) - scale;
                send_element(v << (r == c ? 0 : $urandom_range(16)));
            end
        end
    endtask

    task automatic test_directed();
        write_size(1);
        send_element(32'h0001_0000);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);
        write_size(2);
        send_element(32'h0000_0001);
        send_element(32'h7fff_ffff);
        send_element(32'h0000_0001);
        send_element(32'hffff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h0004_0000);
        // restart a partial load by rewriting the size
        send_element(32'h0004_0000);
        write_size(3);
        send_spd(3, 4);
        write_size(0);
        send_element(32'h0009_0000);
        write_size(15);
        send_spd(8, 2);
    endtask

    task automatic test_random(input int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 5);
            write_size($urandom_range(7) == 0 ? $urandom : n);
            n = order_of(size_reg);
            if ($urandom_range(4) != 0) begin
                send_spd(n, $urandom_range(1, 1000));
            end else begin
                for (int i = 0; i < n * (n + 1) / 2; i++) send_element($urandom);
            end
            sent += n * (n + 1) / 2;
        end
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        loaded = 0;
        err_flag = 0;
        size_reg = 4'(MAX_ORDER);
        send_idle_pct = 36;
        recv_idle_pct = 84;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.element_value = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        send_idle_pct = 84;
        recv_idle_pct = 36;
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);
        drain_results();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
